// ===== rtl/core/mft_pkg.sv =====
package mft_pkg;

    // default frame and timer sizes
    localparam int FRAME_BITS_DEF  = 32;
    localparam int TIMER_WIDTH_DEF = 24;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SAMPLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESP_TIMEOUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD         = 3'd4;

    // register reset values
    localparam logic [15:0] HALF_BIT_RST      = 16'd500;
    localparam logic [15:0] BIT_PERIOD_RST    = 16'd1000;
    localparam logic [16:0] FIRST_SAMPLE_RST  = 17'd1250;
    localparam logic [23:0] RESP_TIMEOUT_RST  = 24'd1000000;
    localparam logic [23:0] GUARD_RST         = 24'd100000;

    // error codes reported with done
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_TIMEOUT = 2'd1;
    localparam logic [1:0] ERR_PARITY  = 2'd2;

    // beat widths on the stream sides
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        logic [15:0] half_bit_ticks;
        logic [15:0] bit_period_ticks;
        logic [16:0] first_sample_ticks;
        logic [23:0] response_timeout_ticks;
        logic [23:0] guard_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  error_code;
        logic [31:0] response_word;
        logic        done_res;
        logic        busy_res;
        logic        tx_level;
    } t_result;

endpackage

// ===== rtl/core/mft_cfg_regs.sv =====
module mft_cfg_regs
    import mft_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_bit_ticks         <= HALF_BIT_RST;
            r_cfg.bit_period_ticks       <= BIT_PERIOD_RST;
            r_cfg.first_sample_ticks     <= FIRST_SAMPLE_RST;
            r_cfg.response_timeout_ticks <= RESP_TIMEOUT_RST;
            r_cfg.guard_ticks            <= GUARD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HALF_BIT:     r_cfg.half_bit_ticks         <= i_cfg_data[15:0];
                CFG_BIT_PERIOD:   r_cfg.bit_period_ticks       <= i_cfg_data[15:0];
                CFG_FIRST_SAMPLE: r_cfg.first_sample_ticks     <= i_cfg_data[16:0];
                CFG_RESP_TIMEOUT: r_cfg.response_timeout_ticks <= i_cfg_data;
                CFG_GUARD:        r_cfg.guard_ticks            <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/mft_engine.sv =====
module mft_engine
    import mft_pkg::*;
#(
    parameter int FRAME_BITS  = FRAME_BITS_DEF,
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_step,
    input  logic        i_start,
    input  logic [31:0] i_req,
    input  logic        i_rx,
    output t_result     o_res
);

    localparam int BW = $clog2(FRAME_BITS + 3);
    localparam int CW = (TIMER_WIDTH > CFG_DATA_W) ? TIMER_WIDTH : CFG_DATA_W;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_TX     = 3'd1;
    localparam logic [2:0] PH_WAIT   = 3'd2;
    localparam logic [2:0] PH_FIRST  = 3'd3;
    localparam logic [2:0] PH_SAMPLE = 3'd4;
    localparam logic [2:0] PH_GUARD  = 3'd5;

    localparam logic [BW-1:0] IDX_LAST_DATA = BW'(FRAME_BITS);
    localparam logic [BW-1:0] IDX_STOP      = BW'(FRAME_BITS + 1);
    localparam logic [BW-1:0] IDX_LAST_SAMP = BW'(FRAME_BITS - 1);

    logic [2:0]             r_phase, n_phase, c_phase;
    logic [TIMER_WIDTH-1:0] r_cnt, n_cnt, c_cnt;
    logic [BW-1:0]          r_idx, n_idx, c_idx;
    logic                   r_half, n_half, c_half;
    logic [FRAME_BITS-1:0]  r_tx, n_tx, c_tx;
    logic [FRAME_BITS-1:0]  r_rx, n_rx, c_rx;
    logic                   r_par, n_par, c_par;

    logic [CFG_DATA_W-1:0]  thr;
    logic [TIMER_WIDTH-1:0] cnt_inc;
    logic                   hit;
    logic                   tx_bit;
    t_result                res;

    // state seen by this beat, a start in idle loads a fresh frame
    always_comb begin
        c_phase = r_phase;
        c_cnt   = r_cnt;
        c_idx   = r_idx;
        c_half  = r_half;
        c_tx    = r_tx;
        c_rx    = r_rx;
        c_par   = r_par;
        if (r_phase == PH_IDLE && i_start) begin
            c_phase = PH_TX;
            c_cnt   = '0;
            c_idx   = '0;
            c_half  = 1'b0;
            c_tx    = i_req[FRAME_BITS-1:0];
            c_rx    = '0;
            c_par   = 1'b0;
        end
    end

    // shared tick timer, saturating, threshold clipped to the timer range
    always_comb begin
        case (c_phase)
            PH_TX:     thr = CFG_DATA_W'(i_cfg.half_bit_ticks);
            PH_WAIT:   thr = i_cfg.response_timeout_ticks;
            PH_FIRST:  thr = CFG_DATA_W'(i_cfg.first_sample_ticks);
            PH_SAMPLE: thr = CFG_DATA_W'(i_cfg.bit_period_ticks);
            PH_GUARD:  thr = i_cfg.guard_ticks;
            default:   thr = '0;
        endcase
    end

    assign cnt_inc = (&c_cnt) ? c_cnt : c_cnt + 1'b1;
    assign hit     = (CW'(cnt_inc) >= CW'(thr)) || (&cnt_inc);

    // start and stop bits are ones, data goes out msb first
    assign tx_bit = (c_idx == '0 || c_idx > IDX_LAST_DATA) ? 1'b1 : c_tx[FRAME_BITS-1];

    // per-beat phase logic
    always_comb begin
        n_phase = c_phase;
        n_cnt   = c_cnt;
        n_idx   = c_idx;
        n_half  = c_half;
        n_tx    = c_tx;
        n_rx    = c_rx;
        n_par   = c_par;

        res               = '0;
        res.tx_level      = 1'b1;
        res.error_code    = ERR_NONE;

        unique case (c_phase) inside
            PH_IDLE: begin
            end
            PH_TX: begin
                res.busy_res = 1'b1;
                res.tx_level = c_half ? tx_bit : ~tx_bit;
                n_cnt        = cnt_inc;
                if (hit) begin
                    n_cnt = '0;
                    if (c_half) begin
                        n_half = 1'b0;
                        n_idx  = c_idx + 1'b1;
                        if (c_idx != '0 && c_idx <= IDX_LAST_DATA) begin
                            n_tx = c_tx << 1;
                        end
                        if (c_idx >= IDX_STOP) begin
                            n_phase = PH_WAIT;
                            n_idx   = '0;
                        end
                    end else begin
                        n_half = 1'b1;
                    end
                end
            end
            PH_WAIT: begin
                if (i_rx) begin
                    res.busy_res = 1'b1;
                    n_phase      = PH_FIRST;
                    n_cnt        = '0;
                end else begin
                    n_cnt = cnt_inc;
                    if (hit) begin
                        res.done_res   = 1'b1;
                        res.error_code = ERR_TIMEOUT;
                        n_phase        = PH_IDLE;
                        n_cnt          = '0;
                    end else begin
                        res.busy_res = 1'b1;
                    end
                end
            end
            PH_FIRST, PH_SAMPLE: begin
                res.busy_res = 1'b1;
                n_cnt        = cnt_inc;
                if (hit) begin
                    n_cnt   = '0;
                    n_rx    = {c_rx[FRAME_BITS-2:0], i_rx};
                    n_par   = c_par ^ i_rx;
                    n_idx   = c_idx + 1'b1;
                    n_phase = (c_idx >= IDX_LAST_SAMP) ? PH_GUARD : PH_SAMPLE;
                end
            end
            PH_GUARD: begin
                n_cnt = cnt_inc;
                if (hit) begin
                    res.done_res = 1'b1;
                    if (c_par) begin
                        res.error_code = ERR_PARITY;
                    end else begin
                        res.response_word = 32'(c_rx);
                    end
                    n_phase = PH_IDLE;
                    n_cnt   = '0;
                    n_idx   = '0;
                end else begin
                    res.busy_res = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_half  <= 1'b0;
            r_par   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_half  <= n_half;
            r_par   <= n_par;
        end
    end

    // frame shift registers
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_tx <= n_tx;
            r_rx <= n_rx;
        end
    end

    assign o_res = res;

`ifndef NO_ASSERTIONS
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.done_res |-> !res.busy_res)
        else $error("done and busy both set");

    a_err_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.error_code != ERR_NONE) |-> res.done_res)
        else $error("error code without done");

    a_resp_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.response_word != '0) |-> (res.done_res && res.error_code == ERR_NONE))
        else $error("response word outside a clean done");

    a_line_idle_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_phase != PH_TX) |-> res.tx_level)
        else $error("tx line low outside the send phase");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_STOP)
        else $error("bit index out of range");
`endif

endmodule

// ===== rtl/core/manchester_frame_transceiver.sv =====
// Manchester frame transceiver, master side of a two-wire link.
// Slave stream: one beat per microsecond tick carrying a start request, the
// 32-bit request word and the receive line level. Master stream: one beat per
// tick with the transmit level, busy, done, response word and error code.
// A start in idle sends a start 1, the frame msb first and a stop 1, each bit
// as two half-bit periods; then the block waits for the response, samples it
// and after the guard delay reports the word, or 0 with a parity error code,
// on a single done beat, or 0 with a timeout code if no response comes.
// A tick beat's result passes the input register, then the result register.
// Throughput: one beat per cycle unless the master stalls; each beat does
// one saturating timer add and compare, a shift and a level update.
// When the master side stalls, the result register holds and the slave side
// keeps taking a beat while the input register is free.
// Configuration is a plain write port; the user writes it only while the
// stream is idle (not enforced by the block). Reset (synchronous, active low)
// returns to idle, empties both registers and loads the default tick counts.
module manchester_frame_transceiver
    import mft_pkg::*;
#(
    parameter int FRAME_BITS  = FRAME_BITS_DEF,
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // tick beats
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // start_req [0], request_word [32:1], rx_level [33], zero pad [39:34]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result beats
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tx_level [0], busy_res [1], done_res [2], response_word [34:3],
    // error_code [36:35], zero pad [39:37]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // register writes
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg                   cfg;
    t_result                res;
    logic                   advance;
    logic                   step;
    logic                   r_in_valid;
    logic [IN_TDATA_W-1:0]  r_in_data;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    mft_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // pipeline moves when the result register is free or being drained
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign step          = r_in_valid && advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
        end
    end

    mft_engine #(
        .FRAME_BITS  (FRAME_BITS),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (step),
        .i_start (r_in_data[0]),
        .i_req   (r_in_data[32:1]),
        .i_rx    (r_in_data[33]),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= OUT_TDATA_W'(res);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== bench/manchester_frame_transceiver_tb.sv =====
module manchester_frame_transceiver_tb;
    import mft_pkg::*;

    localparam int          LINK_BITS     = FRAME_BITS_DEF;
    localparam int unsigned TIMER_MAX     = (1 << TIMER_WIDTH_DEF) - 1;
    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          NEVER_HIGH    = 1 << 30;
    localparam int          STALL_STRETCH = 400;

    typedef enum logic [2:0] {
        LINK_IDLE,
        LINK_TX,
        LINK_WAIT,
        LINK_FIRST,
        LINK_SAMPLE,
        LINK_GUARD
    } t_link_phase;

    // tracks the link state per tick and holds the result beats still due
    class t_frame_ledger;
        logic [15:0] half_bit;
        logic [15:0] bit_period;
        logic [16:0] first_sample;
        logic [23:0] resp_timeout;
        logic [23:0] guard;

        t_link_phase phase;
        int unsigned ticks;
        int unsigned bit_index;
        bit          second_half;
        logic [31:0] tx_word;
        logic [31:0] rx_shift;
        bit          rx_parity;

        t_result     expected_beats[$];
        int          fails;

        function new();
            half_bit     = HALF_BIT_RST;
            bit_period   = BIT_PERIOD_RST;
            first_sample = FIRST_SAMPLE_RST;
            resp_timeout = RESP_TIMEOUT_RST;
            guard        = GUARD_RST;
            phase        = LINK_IDLE;
            ticks        = 0;
            bit_index    = 0;
            second_half  = 1'b0;
            tx_word      = '0;
            rx_shift     = '0;
            rx_parity    = 1'b0;
            fails        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_HALF_BIT:     half_bit     = value[15:0];
                CFG_BIT_PERIOD:   bit_period   = value[15:0];
                CFG_FIRST_SAMPLE: first_sample = value[16:0];
                CFG_RESP_TIMEOUT: resp_timeout = value[23:0];
                CFG_GUARD:        guard        = value[23:0];
                default: ;
            endcase
        endfunction

        // saturating tick counter, threshold clipped to [1, timer max]
        function bit tick_reaches(int unsigned threshold);
            int unsigned lim;
            lim = threshold;
            if (lim > TIMER_MAX) lim = TIMER_MAX;
            if (lim == 0) lim = 1;
            if (ticks < TIMER_MAX) ticks++;
            return ticks >= lim;
        endfunction

        function void shift_in(bit lvl);
            rx_shift  = {rx_shift[30:0], lvl};
            rx_parity = rx_parity ^ lvl;
            bit_index++;
        endfunction

        // one accepted tick beat: advance the link and queue its result
        function void note_tick(bit start, logic [31:0] word, bit lvl);
            t_result r;
            bit      b;
            r          = '0;
            r.tx_level = 1'b1;
            if (phase == LINK_IDLE && start) begin
                tx_word     = word;
                phase       = LINK_TX;
                ticks       = 0;
                bit_index   = 0;
                second_half = 1'b0;
                rx_shift    = '0;
                rx_parity   = 1'b0;
            end
            case (phase)
                LINK_TX: begin
                    r.busy_res = 1'b1;
                    // start and stop bits are ones
                    if (bit_index == 0 || bit_index > LINK_BITS)
                        b = 1'b1;
                    else
                        b = tx_word[LINK_BITS - bit_index];
                    r.tx_level = second_half ? b : ~b;
                    if (tick_reaches(half_bit)) begin
                        ticks = 0;
                        if (second_half) begin
                            second_half = 1'b0;
                            bit_index++;
                            if (bit_index > LINK_BITS + 1) begin
                                phase     = LINK_WAIT;
                                bit_index = 0;
                            end
                        end else begin
                            second_half = 1'b1;
                        end
                    end
                end
                LINK_WAIT: begin
                    if (lvl) begin
                        r.busy_res = 1'b1;
                        phase      = LINK_FIRST;
                        ticks      = 0;
                    end else if (tick_reaches(resp_timeout)) begin
                        r.done_res   = 1'b1;
                        r.error_code = ERR_TIMEOUT;
                        phase        = LINK_IDLE;
                        ticks        = 0;
                    end else begin
                        r.busy_res = 1'b1;
                    end
                end
                LINK_FIRST: begin
                    r.busy_res = 1'b1;
                    if (tick_reaches(first_sample)) begin
                        ticks = 0;
                        shift_in(lvl);
                        phase = (bit_index >= LINK_BITS) ? LINK_GUARD : LINK_SAMPLE;
                    end
                end
                LINK_SAMPLE: begin
                    r.busy_res = 1'b1;
                    if (tick_reaches(bit_period)) begin
                        ticks = 0;
                        shift_in(lvl);
                        if (bit_index >= LINK_BITS) phase = LINK_GUARD;
                    end
                end
                LINK_GUARD: begin
                    if (tick_reaches(guard)) begin
                        r.done_res = 1'b1;
                        if (rx_parity)
                            r.error_code = ERR_PARITY;
                        else
                            r.response_word = rx_shift;
                        phase     = LINK_IDLE;
                        ticks     = 0;
                        bit_index = 0;
                    end else begin
                        r.busy_res = 1'b1;
                    end
                end
                default: ;
            endcase
            expected_beats.push_back(r);
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                fails++;
            end
        endfunction

        // one accepted result beat against the oldest one due
        function void check_beat(logic [OUT_TDATA_W-1:0] beat);
            t_result want;
            t_result got;
            got = beat[$bits(t_result)-1:0];
            if (expected_beats.size() == 0) begin
                $display("%0t: result beat with none due, expected nothing actual %h",
                         $time, beat);
                fails++;
                return;
            end
            want = expected_beats.pop_front();
            match_field("tx_level", want.tx_level, got.tx_level);
            match_field("busy_res", want.busy_res, got.busy_res);
            match_field("done_res", want.done_res, got.done_res);
            match_field("response_word", want.response_word, got.response_word);
            match_field("error_code", want.error_code, got.error_code);
            match_field("pad", '0, beat[OUT_TDATA_W-1:$bits(t_result)]);
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    // receiver controls; hold_go and out_calm are set by the stimulus process
    logic hold_go  = 1'b0;
    logic out_calm = 1'b0;
    bit   hold_taken = 1'b0;
    int   hold_left  = 0;

    // sender controls
    bit send_calm       = 1'b0;
    bit drain_first     = 1'b0;
    bit pause_in_sample = 1'b0;

    int cycle_count = 0;

    t_frame_ledger ledger;

    manchester_frame_transceiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            ledger.check_beat(m_axis_tdata);
        if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = STALL_STRETCH;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= out_calm || ($urandom_range(99) >= 33);
        end
    end

    // offer one tick beat, with optional idle cycles or a drain in front
    task automatic offer_tick(input bit start, input logic [31:0] word, input bit lvl);
        if (drain_first) begin
            drain_first = 1'b0;
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while (ledger.expected_beats.size() != 0);
        end else begin
            while (!send_calm && $urandom_range(99) < 33) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - 34){1'b0}}, lvl, word, start};
        do @(posedge i_clk); while (!s_axis_tready);
        ledger.note_tick(start, word, lvl);
    endtask

    // ticks with no start request
    task automatic quiet_ticks(input int count);
        for (int k = 0; k < count; k++)
            offer_tick(1'b0, $urandom, 1'($urandom_range(1)));
    endtask

    // one transaction from start to done; the line answers with reply
    // after low_ticks low ticks in the wait phase
    task automatic run_frame(input logic [31:0] word, input logic [31:0] reply,
                             input int low_ticks);
        bit start;
        bit lvl;
        int wait_low;
        wait_low = low_ticks;
        offer_tick(1'b1, word, 1'($urandom_range(1)));
        while (ledger.phase != LINK_IDLE) begin
            if (pause_in_sample && ledger.phase == LINK_SAMPLE) begin
                pause_in_sample = 1'b0;
                drain_first     = 1'b1;
            end
            // starts while busy must be ignored
            start = ($urandom_range(3) == 0);
            case (ledger.phase) inside
                LINK_WAIT: begin
                    lvl = (wait_low == 0);
                    if (wait_low > 0) wait_low--;
                end
                LINK_FIRST, LINK_SAMPLE: lvl = reply[LINK_BITS - 1 - ledger.bit_index];
                default: lvl = 1'($urandom_range(1));
            endcase
            offer_tick(start, $urandom, lvl);
        end
    endtask

    // stop offering and let every due result drain out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (ledger.expected_beats.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        ledger.write_reg(idx, value);
    endtask

    // all five timing registers, plus a stray write past the last index
    task automatic load_timing(input logic [23:0] h_ticks, input logic [23:0] p_ticks,
                               input logic [23:0] f_ticks, input logic [23:0] t_ticks,
                               input logic [23:0] g_ticks);
        cfg_write(CFG_GUARD + 3'($urandom_range(1, 3)), 24'($urandom));
        cfg_write(CFG_HALF_BIT, h_ticks);
        cfg_write(CFG_BIT_PERIOD, p_ticks);
        cfg_write(CFG_FIRST_SAMPLE, f_ticks);
        cfg_write(CFG_RESP_TIMEOUT, t_ticks);
        cfg_write(CFG_GUARD, g_ticks);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int k;
        int p;
        int low;
        ledger = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset timing: line idles high, extreme words with no start
        for (k = 0; k < 8; k++)
            offer_tick(1'b0, k[0] ? 32'hFFFF_FFFF : 32'h0000_0000, k[1]);

        // shortest half bit, zero guard, longest timeout
        // first frame with both sides never idling
        settle();
        load_timing(24'd1, 24'd1, 24'd1, 24'hFF_FFFF, 24'd0);
        send_calm = 1'b1;
        out_calm <= 1'b1;
        run_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_calm = 1'b0;
        out_calm <= 1'b0;
        run_frame(32'h0000_0000, 32'h0000_0001, 3);
        run_frame(32'h8000_0001, 32'h8000_0001, 1);

        // shortest timeout; upper half-bit data bits are masked off
        settle();
        load_timing(24'h5A_0001, 24'd2, 24'd3, 24'd1, 24'd1);
        run_frame($urandom, $urandom, NEVER_HIGH);
        run_frame(32'h0000_FFFF, 32'h0000_0000, 0);

        // every register at its top value, idle ticks only
        settle();
        load_timing(24'hFF_FFFF, 24'h00_FFFF, 24'h01_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        quiet_ticks(20);

        // random short timings, one long receiver hold-off, one drain mid-frame
        for (p = 0; p < 2; p++) begin
            settle();
            load_timing(24'd1, 24'($urandom_range(1, 2)),
                        24'($urandom_range(1, 6)), 24'($urandom_range(1, 40)),
                        24'($urandom_range(0, 6)));
            if (p == 0) hold_go <= 1'b1;
            if (p == 1) pause_in_sample = 1'b1;
            quiet_ticks($urandom_range(0, 4));
            low = ($urandom_range(99) < 15) ? NEVER_HIGH : $urandom_range(0, 6);
            run_frame($urandom, $urandom, low);
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (ledger.expected_beats.size() != 0);
        repeat (8) @(posedge i_clk);
        if (ledger.fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mft_pkg.sv
rtl/core/mft_cfg_regs.sv
rtl/core/mft_engine.sv
rtl/core/manchester_frame_transceiver.sv
bench/manchester_frame_transceiver_tb.sv
